>>> src/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// Used by i2cm_core and i2c_master_byte_engine; depends on nothing.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = 4;
  localparam int HALF_W        = 8;
  localparam int WAIT_W        = 16;
  localparam int CMD_W         = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd5;
  localparam logic [WAIT_W-1:0] ACK_WAIT_RESET    = 16'd0;
  localparam logic [WAIT_W-1:0] ACK_WAIT_MAX      = 16'hFFFF;

  // Command codes on the input kind field
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_LIMIT   = 1'b1;

  // ACK flag codes (bit 0 ack seen, bit 1 timeout)
  localparam logic [1:0] ACK_NONE    = 2'b00;
  localparam logic [1:0] ACK_SEEN    = 2'b01;
  localparam logic [1:0] ACK_TIMEOUT = 2'b10;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_ST_A    = 15'b000000000000010,
    PH_ST_B    = 15'b000000000000100,
    PH_SP_A    = 15'b000000000001000,
    PH_SP_B    = 15'b000000000010000,
    PH_WR_LOW  = 15'b000000000100000,
    PH_WR_HIGH = 15'b000000001000000,
    PH_AK_LOW  = 15'b000000010000000,
    PH_AK_HIGH = 15'b000000100000000,
    PH_AK_WAIT = 15'b000001000000000,
    PH_AK_TAIL = 15'b000010000000000,
    PH_RD_LOW  = 15'b000100000000000,
    PH_RD_HIGH = 15'b001000000000000,
    PH_NK_LOW  = 15'b010000000000000,
    PH_NK_HIGH = 15'b100000000000000
  } phase_t;

  // Result of one step, handed from the core to the output register
  typedef struct packed {
    logic       ack_timeout;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

>>> src/i2cm_core.sv
// Bus sequencer state and its next-state logic for one item per step.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [i2cm_pkg::CMD_W-1:0]      command,
  input  logic [7:0]                      write_byte,
  input  logic                            sda_in,
  input  logic [i2cm_pkg::HALF_W-1:0]     half_period,
  input  logic [i2cm_pkg::WAIT_W-1:0]     ack_wait_limit,
  output i2cm_pkg::res_t                  res
);

  i2cm_pkg::phase_t                    phase, phase_next;
  logic [i2cm_pkg::BIT_CNT_W-1:0]      bit_count, bit_count_next;
  logic [7:0]                          shift_reg, shift_reg_next;
  logic [i2cm_pkg::HALF_W-1:0]         phase_ticks, phase_ticks_next;
  logic [i2cm_pkg::WAIT_W-1:0]         ack_wait_ticks, ack_wait_ticks_next;
  logic                                scl_level, scl_level_next;
  logic                                sda_level, sda_level_next;
  logic [7:0]                          received_byte, received_byte_next;
  logic [1:0]                          ack_flags, ack_flags_next;
  logic                                finished;

  always_comb begin
    logic [i2cm_pkg::HALF_W-1:0]    h;
    logic [i2cm_pkg::HALF_W-1:0]    ticks_inc;
    logic [i2cm_pkg::BIT_CNT_W-1:0] cnt_inc;
    logic [7:0]                     sh_wr;
    logic [7:0]                     sh_rd;
    logic [i2cm_pkg::WAIT_W-1:0]    wait_inc;

    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    phase_ticks_next    = phase_ticks;
    ack_wait_ticks_next = ack_wait_ticks;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    received_byte_next  = received_byte;
    ack_flags_next      = ack_flags;
    finished            = 1'b0;

    h         = (half_period == '0) ? i2cm_pkg::HALF_W'(1) : half_period;
    ticks_inc = phase_ticks + i2cm_pkg::HALF_W'(1);
    cnt_inc   = bit_count + i2cm_pkg::BIT_CNT_W'(1);
    sh_wr     = {shift_reg[6:0], 1'b0};
    sh_rd     = {shift_reg[6:0], sda_in};
    wait_inc  = (ack_wait_ticks < i2cm_pkg::ACK_WAIT_MAX) ?
                ack_wait_ticks + i2cm_pkg::WAIT_W'(1) : ack_wait_ticks;

    if (phase == i2cm_pkg::PH_IDLE) begin
      phase_ticks_next = '0;
      case (command)
        i2cm_pkg::CMD_START: begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          phase_next     = i2cm_pkg::PH_ST_A;
        end
        i2cm_pkg::CMD_STOP: begin
          scl_level_next = 1'b0;
          sda_level_next = 1'b0;
          phase_next     = i2cm_pkg::PH_SP_A;
        end
        i2cm_pkg::CMD_WRITE: begin
          shift_reg_next      = write_byte;
          bit_count_next      = '0;
          ack_flags_next      = i2cm_pkg::ACK_NONE;
          ack_wait_ticks_next = '0;
          scl_level_next      = 1'b0;
          sda_level_next      = write_byte[7];
          phase_next          = i2cm_pkg::PH_WR_LOW;
        end
        i2cm_pkg::CMD_READ: begin
          shift_reg_next = '0;
          bit_count_next = '0;
          scl_level_next = 1'b0;
          sda_level_next = 1'b1;
          phase_next     = i2cm_pkg::PH_RD_LOW;
        end
        default: begin
          phase_ticks_next = phase_ticks;
        end
      endcase
    end else if (phase == i2cm_pkg::PH_AK_WAIT) begin
      // Poll for ACK every tick; the phase counter does not run here
      if (!sda_in) begin
        ack_flags_next   = i2cm_pkg::ACK_SEEN;
        scl_level_next   = 1'b0;
        phase_next       = i2cm_pkg::PH_AK_TAIL;
        phase_ticks_next = '0;
      end else begin
        ack_wait_ticks_next = wait_inc;
        if (ack_wait_limit != '0 && wait_inc >= ack_wait_limit) begin
          ack_flags_next   = i2cm_pkg::ACK_TIMEOUT;
          scl_level_next   = 1'b0;
          phase_next       = i2cm_pkg::PH_AK_TAIL;
          phase_ticks_next = '0;
        end
      end
    end else begin
      phase_ticks_next = ticks_inc;
      if (ticks_inc >= h) begin
        phase_ticks_next = '0;
        case (phase)
          i2cm_pkg::PH_ST_A: begin
            sda_level_next = 1'b0;
            phase_next     = i2cm_pkg::PH_ST_B;
          end
          i2cm_pkg::PH_SP_A: begin
            scl_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_SP_B;
          end
          i2cm_pkg::PH_SP_B: begin
            sda_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_IDLE;
            finished       = 1'b1;
          end
          i2cm_pkg::PH_WR_LOW: begin
            scl_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_WR_HIGH;
          end
          i2cm_pkg::PH_WR_HIGH: begin
            scl_level_next = 1'b0;
            shift_reg_next = sh_wr;
            bit_count_next = cnt_inc;
            if (cnt_inc >= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BITS_PER_BYTE)) begin
              sda_level_next = 1'b1;
              phase_next     = i2cm_pkg::PH_AK_LOW;
            end else begin
              sda_level_next = sh_wr[7];
              phase_next     = i2cm_pkg::PH_WR_LOW;
            end
          end
          i2cm_pkg::PH_AK_LOW: begin
            scl_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_AK_HIGH;
          end
          i2cm_pkg::PH_AK_HIGH: begin
            ack_wait_ticks_next = '0;
            phase_next          = i2cm_pkg::PH_AK_WAIT;
          end
          i2cm_pkg::PH_RD_LOW: begin
            scl_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_RD_HIGH;
          end
          i2cm_pkg::PH_RD_HIGH: begin
            shift_reg_next = sh_rd;
            scl_level_next = 1'b0;
            bit_count_next = cnt_inc;
            if (cnt_inc >= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BITS_PER_BYTE)) begin
              received_byte_next = sh_rd;
              sda_level_next     = 1'b1;
              phase_next         = i2cm_pkg::PH_NK_LOW;
            end else begin
              phase_next = i2cm_pkg::PH_RD_LOW;
            end
          end
          i2cm_pkg::PH_NK_LOW: begin
            scl_level_next = 1'b1;
            phase_next     = i2cm_pkg::PH_NK_HIGH;
          end
          i2cm_pkg::PH_NK_HIGH: begin
            scl_level_next = 1'b0;
            phase_next     = i2cm_pkg::PH_IDLE;
            finished       = 1'b1;
          end
          i2cm_pkg::PH_ST_B: begin
            scl_level_next = 1'b0;
            phase_next     = i2cm_pkg::PH_IDLE;
            finished       = 1'b1;
          end
          default: begin
            // Ack tail and anything unexpected end the sequence
            phase_next = i2cm_pkg::PH_IDLE;
            finished   = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cm_pkg::PH_IDLE;
      bit_count      <= '0;
      shift_reg      <= '0;
      phase_ticks    <= '0;
      ack_wait_ticks <= '0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      received_byte  <= '0;
      ack_flags      <= i2cm_pkg::ACK_NONE;
    end else if (step) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      phase_ticks    <= phase_ticks_next;
      ack_wait_ticks <= ack_wait_ticks_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      received_byte  <= received_byte_next;
      ack_flags      <= ack_flags_next;
    end
  end

  assign res.scl_out     = scl_level_next;
  assign res.sda_out     = sda_level_next;
  assign res.busy_res    = (phase_next != i2cm_pkg::PH_IDLE);
  assign res.done_res    = finished;
  assign res.read_byte   = received_byte_next;
  assign res.ack_seen    = ack_flags_next[0];
  assign res.ack_timeout = ack_flags_next[1];

  a_write_clears_flags: assert property (@(posedge clk) disable iff (rst)
    (step && phase == i2cm_pkg::PH_IDLE && command == i2cm_pkg::CMD_WRITE)
    |=> (phase == i2cm_pkg::PH_WR_LOW && ack_flags == i2cm_pkg::ACK_NONE))
    else $error("write command did not enter the first bit with flags cleared");

  a_ack_low_seen: assert property (@(posedge clk) disable iff (rst)
    (step && phase == i2cm_pkg::PH_AK_WAIT && !sda_in)
    |=> (phase == i2cm_pkg::PH_AK_TAIL && ack_flags == i2cm_pkg::ACK_SEEN && !scl_level))
    else $error("low SDA during ACK wait not taken as ACK");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    ack_flags != (i2cm_pkg::ACK_SEEN | i2cm_pkg::ACK_TIMEOUT))
    else $error("ACK seen and timeout both set");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BITS_PER_BYTE))
    else $error("bit counter ran past a byte");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (step && res.done_res) |=> (phase == i2cm_pkg::PH_IDLE))
    else $error("sequence finished but engine not idle");

endmodule

>>> src/i2c_master_byte_engine.sv
// I2C master byte engine: a bus sequencer that produces SCL/SDA levels
// from a stream of tick and command items; one result item per input item.
// Depends on i2cm_pkg and i2cm_core.
`timescale 1ns / 1ps

// Feed one transaction per bus time tick on the slave side. While the engine
// is idle, tuser carries a command (start, stop, write byte, read byte) that
// launches a bus sequence; any other transaction, and every transaction while
// busy, counts as one tick and carries the sampled SDA level in tdata. Each
// bus phase lasts half_period ticks (zero behaves as one). After a written
// byte the engine releases SDA and polls for ACK on every tick; a nonzero
// ack_wait_limit ends that wait with ack_timeout set. Every input transaction
// yields exactly one output transaction with the SCL/SDA levels to drive,
// busy, a one-item done pulse, the last read byte and the ACK flags. The
// engine takes one transaction per clock unless the result is held back
// by m_tready; an accepted transaction passes the input register and the
// sequencer step into the result register. Write configuration only while
// the engine is idle; configuration writes are always accepted.
module i2c_master_byte_engine (
  input  logic                              clk,
  input  logic                              rst,
  // Slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,  // [7:0] write_byte, [8] sda_in
  input  logic [i2cm_pkg::CMD_W-1:0]        s_tuser,  // [2:0] command
  // Master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_seen, [13] ack_timeout
  output logic [15:0]                       m_tdata,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [i2cm_pkg::HALF_W-1:0] half_period;
  logic [i2cm_pkg::WAIT_W-1:0] ack_wait_limit;

  logic                        in_valid;
  logic [i2cm_pkg::CMD_W-1:0]  in_command;
  logic [7:0]                  in_write_byte;
  logic                        in_sda;
  logic                        advance;
  i2cm_pkg::res_t              res;

  // Configuration: always ready, write straight into the registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period    <= i2cm_pkg::HALF_PERIOD_RESET;
      ack_wait_limit <= i2cm_pkg::ACK_WAIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2cm_pkg::CFG_HALF_PERIOD: half_period    <= cfg_data[i2cm_pkg::HALF_W-1:0];
        i2cm_pkg::CFG_ACK_LIMIT:   ack_wait_limit <= cfg_data[i2cm_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held item into the sequencer when the result slot is free
  // or is being emptied this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_command    <= s_tuser;
      in_write_byte <= s_tdata[7:0];
      in_sda        <= s_tdata[8];
    end
  end

  i2cm_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .command        (in_command),
    .write_byte     (in_write_byte),
    .sda_in         (in_sda),
    .half_period    (half_period),
    .ack_wait_limit (ack_wait_limit),
    .res            (res)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, res.ack_timeout, res.ack_seen, res.read_byte,
                  res.done_res, res.busy_res, res.sda_out, res.scl_out};
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending result overwritten");

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("held input item lost");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("advanced item produced no result");

endmodule

>>> verif/i2c_master_byte_engine_tb.sv
// Self-checking testbench for i2c_master_byte_engine: streams tick and command
// transactions, predicts every result transaction and compares them in order.
// Depends on i2cm_pkg and the engine RTL only.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_HOLD      = 60;

  // Command codes the engine does not define; they act as plain ticks
  localparam logic [i2cm_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [i2cm_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [i2cm_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // SDA level choice for a run of ticks
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  typedef struct packed {
    logic [i2cm_pkg::CMD_W-1:0] cmd;
    logic [7:0]                 wbyte;
    logic                       sda;
  } bus_item_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [15:0]                     s_tdata = '0;
  logic [i2cm_pkg::CMD_W-1:0]      s_tuser = i2cm_pkg::CMD_TICK;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [15:0]                     m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = i2cm_pkg::CFG_HALF_PERIOD;
  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Items waiting for the driver, and bus results still owed by the engine
  bus_item_t       pending_items[$];
  i2cm_pkg::res_t  results_owed[$];
  bus_item_t       next_item;
  i2cm_pkg::res_t  bus_seen;
  i2cm_pkg::res_t  bus_due;

  int  queued_total = 0;
  int  fail_count = 0;
  int  result_index = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  send_idle_pct = 5;
  int  recv_idle_pct = 5;
  bit  hold_off_req = 1'b0;

  // Sequencer shadow: register settings and bus state, reset values
  logic [i2cm_pkg::HALF_W-1:0]    half_setting = i2cm_pkg::HALF_PERIOD_RESET;
  logic [i2cm_pkg::WAIT_W-1:0]    limit_setting = i2cm_pkg::ACK_WAIT_RESET;
  i2cm_pkg::phase_t               seq_phase = i2cm_pkg::PH_IDLE;
  logic [i2cm_pkg::BIT_CNT_W-1:0] bits_done = '0;
  logic [7:0]                     shifter = '0;
  logic [7:0]                     phase_cnt = '0;
  logic [i2cm_pkg::WAIT_W-1:0]    ack_wait_cnt = '0;
  logic                           scl_q = 1'b1;
  logic                           sda_q = 1'b1;
  logic [7:0]                     rx_byte = '0;
  logic [1:0]                     ack_state = i2cm_pkg::ACK_NONE;

  i2c_master_byte_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A zero phase length behaves as one tick
  function automatic int ticks_per_phase();
    return (half_setting == '0) ? 1 : int'(half_setting);
  endfunction

  // Advance the bus sequencer by one accepted transaction and return the levels
  // and flags it shows afterwards.
  function automatic i2cm_pkg::res_t bus_step(input logic [i2cm_pkg::CMD_W-1:0] cmd,
                                              input logic [7:0] wb, input logic sda);
    i2cm_pkg::res_t r;
    logic fin;
    fin = 1'b0;
    if (seq_phase == i2cm_pkg::PH_IDLE) begin
      // Only an idle engine takes commands; undefined codes just pass as ticks
      case (cmd)
        i2cm_pkg::CMD_START: begin
          scl_q = 1'b1; sda_q = 1'b1; seq_phase = i2cm_pkg::PH_ST_A; phase_cnt = '0;
        end
        i2cm_pkg::CMD_STOP: begin
          scl_q = 1'b0; sda_q = 1'b0; seq_phase = i2cm_pkg::PH_SP_A; phase_cnt = '0;
        end
        i2cm_pkg::CMD_WRITE: begin
          shifter = wb; bits_done = '0; ack_state = i2cm_pkg::ACK_NONE; ack_wait_cnt = '0;
          scl_q = 1'b0; sda_q = wb[7]; seq_phase = i2cm_pkg::PH_WR_LOW; phase_cnt = '0;
        end
        i2cm_pkg::CMD_READ: begin
          shifter = '0; bits_done = '0;
          scl_q = 1'b0; sda_q = 1'b1; seq_phase = i2cm_pkg::PH_RD_LOW; phase_cnt = '0;
        end
        default: ;
      endcase
    end else if (seq_phase == i2cm_pkg::PH_AK_WAIT) begin
      // Poll for ACK on every tick; the wait count saturates at full scale
      if (!sda) begin
        ack_state = i2cm_pkg::ACK_SEEN; scl_q = 1'b0;
        seq_phase = i2cm_pkg::PH_AK_TAIL; phase_cnt = '0;
      end else begin
        if (ack_wait_cnt != i2cm_pkg::ACK_WAIT_MAX)
          ack_wait_cnt = ack_wait_cnt + 16'd1;
        if (limit_setting != '0 && ack_wait_cnt >= limit_setting) begin
          ack_state = i2cm_pkg::ACK_TIMEOUT; scl_q = 1'b0;
          seq_phase = i2cm_pkg::PH_AK_TAIL; phase_cnt = '0;
        end
      end
    end else begin
      phase_cnt = phase_cnt + 8'd1;
      if (int'(phase_cnt) >= ticks_per_phase()) begin
        phase_cnt = '0;
        case (seq_phase)
          i2cm_pkg::PH_ST_A: begin
            sda_q = 1'b0; seq_phase = i2cm_pkg::PH_ST_B;
          end
          i2cm_pkg::PH_ST_B: begin
            scl_q = 1'b0; seq_phase = i2cm_pkg::PH_IDLE; fin = 1'b1;
          end
          i2cm_pkg::PH_SP_A: begin
            scl_q = 1'b1; seq_phase = i2cm_pkg::PH_SP_B;
          end
          i2cm_pkg::PH_SP_B: begin
            sda_q = 1'b1; seq_phase = i2cm_pkg::PH_IDLE; fin = 1'b1;
          end
          i2cm_pkg::PH_WR_LOW: begin
            scl_q = 1'b1; seq_phase = i2cm_pkg::PH_WR_HIGH;
          end
          i2cm_pkg::PH_WR_HIGH: begin
            scl_q = 1'b0;
            shifter = shifter << 1;
            bits_done = bits_done + 4'd1;
            if (bits_done >= i2cm_pkg::BITS_PER_BYTE) begin
              sda_q = 1'b1; seq_phase = i2cm_pkg::PH_AK_LOW;
            end else begin
              sda_q = shifter[7]; seq_phase = i2cm_pkg::PH_WR_LOW;
            end
          end
          i2cm_pkg::PH_AK_LOW: begin
            scl_q = 1'b1; seq_phase = i2cm_pkg::PH_AK_HIGH;
          end
          i2cm_pkg::PH_AK_HIGH: begin
            ack_wait_cnt = '0; seq_phase = i2cm_pkg::PH_AK_WAIT;
          end
          i2cm_pkg::PH_AK_TAIL: begin
            seq_phase = i2cm_pkg::PH_IDLE; fin = 1'b1;
          end
          i2cm_pkg::PH_RD_LOW: begin
            scl_q = 1'b1; seq_phase = i2cm_pkg::PH_RD_HIGH;
          end
          i2cm_pkg::PH_RD_HIGH: begin
            // Sample SDA on the tick that closes the high phase
            shifter = {shifter[6:0], sda};
            scl_q = 1'b0;
            bits_done = bits_done + 4'd1;
            if (bits_done >= i2cm_pkg::BITS_PER_BYTE) begin
              rx_byte = shifter; sda_q = 1'b1; seq_phase = i2cm_pkg::PH_NK_LOW;
            end else begin
              seq_phase = i2cm_pkg::PH_RD_LOW;
            end
          end
          i2cm_pkg::PH_NK_LOW: begin
            scl_q = 1'b1; seq_phase = i2cm_pkg::PH_NK_HIGH;
          end
          i2cm_pkg::PH_NK_HIGH: begin
            scl_q = 1'b0; seq_phase = i2cm_pkg::PH_IDLE; fin = 1'b1;
          end
          default: begin
            seq_phase = i2cm_pkg::PH_IDLE; fin = 1'b1;
          end
        endcase
      end
    end
    r.scl_out     = scl_q;
    r.sda_out     = sda_q;
    r.busy_res    = (seq_phase != i2cm_pkg::PH_IDLE);
    r.done_res    = fin;
    r.read_byte   = rx_byte;
    r.ack_seen    = ack_state[0];
    r.ack_timeout = ack_state[1];
    return r;
  endfunction

  // Driver: hold an item until its transaction completes, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= i2cm_pkg::CMD_TICK;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        results_owed.push_back(bus_step(s_tuser, s_tdata[7:0], s_tdata[8]));
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
          // Start a burst of idle cycles, this one included
          send_gap = $urandom_range(12);
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'b0, next_item.sda, next_item.wbyte};
          s_tuser  <= next_item.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest owed result
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        bus_seen.scl_out     = m_tdata[0];
        bus_seen.sda_out     = m_tdata[1];
        bus_seen.busy_res    = m_tdata[2];
        bus_seen.done_res    = m_tdata[3];
        bus_seen.read_byte   = m_tdata[11:4];
        bus_seen.ack_seen    = m_tdata[12];
        bus_seen.ack_timeout = m_tdata[13];
        if (results_owed.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d arrived with nothing owed: %h", result_index, m_tdata);
        end else begin
          bus_due = results_owed.pop_front();
          if (bus_seen.scl_out !== bus_due.scl_out || bus_seen.sda_out !== bus_due.sda_out ||
              bus_seen.busy_res !== bus_due.busy_res ||
              bus_seen.done_res !== bus_due.done_res ||
              bus_seen.read_byte !== bus_due.read_byte ||
              bus_seen.ack_seen !== bus_due.ack_seen ||
              bus_seen.ack_timeout !== bus_due.ack_timeout) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"result %0d mismatch (scl sda busy done rd ack tmo):",
                        " expected %b %b %b %b %h %b %b, got %b %b %b %b %h %b %b"},
                       result_index,
                       bus_due.scl_out, bus_due.sda_out, bus_due.busy_res, bus_due.done_res,
                       bus_due.read_byte, bus_due.ack_seen, bus_due.ack_timeout,
                       bus_seen.scl_out, bus_seen.sda_out, bus_seen.busy_res,
                       bus_seen.done_res, bus_seen.read_byte, bus_seen.ack_seen,
                       bus_seen.ack_timeout);
          end
        end
        result_index++;
      end
      // A requested long hold-off lets the engine fill up and stall its input
      if (hold_off_req && recv_stall == 0) begin
        hold_off_req = 1'b0;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        recv_stall = $urandom_range(12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic queue_item(input logic [i2cm_pkg::CMD_W-1:0] cmd, input logic [7:0] wb,
                            input logic sda);
    bus_item_t it;
    it.cmd   = cmd;
    it.wbyte = wb;
    it.sda   = sda;
    pending_items.push_back(it);
    queued_total++;
  endtask

  // Ticks inside a running sequence; now and then one carries a command that
  // the busy engine must ignore.
  task automatic queue_ticks(input int n, input int sda_mode);
    logic [i2cm_pkg::CMD_W-1:0] cmd;
    logic                       sda;
    for (int k = 0; k < n; k++) begin
      cmd = ($urandom_range(15) == 0) ? i2cm_pkg::CMD_W'($urandom_range(1, 7)) :
            i2cm_pkg::CMD_TICK;
      sda = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(1)) : (sda_mode == SDA_HIGH);
      queue_item(cmd, 8'($urandom), sda);
    end
  endtask

  // Items seen by an idle engine that start nothing
  task automatic queue_idle_noise(input int n);
    logic [i2cm_pkg::CMD_W-1:0] cmd;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: cmd = i2cm_pkg::CMD_TICK;
        1: cmd = CMD_SPARE_5;
        2: cmd = CMD_SPARE_6;
        default: cmd = CMD_SPARE_7;
      endcase
      queue_item(cmd, 8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // Start and stop conditions both span two phases
  task automatic queue_condition(input logic [i2cm_pkg::CMD_W-1:0] cmd);
    queue_item(cmd, 8'($urandom), 1'($urandom_range(1)));
    queue_ticks(2 * ticks_per_phase(), SDA_RANDOM);
  endtask

  // Eight bits plus the ACK clock, then `waits` released ticks, then either the
  // ACK or nothing (the last released tick hits the limit), then the tail.
  task automatic queue_write(input logic [7:0] wb, input int waits, input bit acked);
    queue_item(i2cm_pkg::CMD_WRITE, wb, 1'($urandom_range(1)));
    queue_ticks(18 * ticks_per_phase(), SDA_RANDOM);
    queue_ticks(waits, SDA_HIGH);
    if (acked)
      queue_ticks(1, SDA_LOW);
    queue_ticks(ticks_per_phase(), SDA_RANDOM);
  endtask

  task automatic queue_read(input int sda_mode);
    queue_item(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom_range(1)));
    queue_ticks(18 * ticks_per_phase(), sda_mode);
  endtask

  task automatic fill_sequences(input int budget);
    int          target;
    int          waits;
    logic [7:0]  wb;
    target = queued_total + budget;
    while (queued_total < target) begin
      case ($urandom_range(9))
        0, 1: queue_condition(i2cm_pkg::CMD_START);
        2:    queue_condition(i2cm_pkg::CMD_STOP);
        3, 4, 5, 6: begin
          case ($urandom_range(7))
            0: wb = 8'h00;
            1: wb = 8'hFF;
            default: wb = 8'($urandom);
          endcase
          if (limit_setting != '0 && $urandom_range(2) == 0) begin
            queue_write(wb, int'(limit_setting), 1'b0);
          end else begin
            waits = (limit_setting == '0 || limit_setting > 16'd8) ? 8 :
                    int'(limit_setting) - 1;
            queue_write(wb, $urandom_range(waits), 1'b1);
          end
        end
        default: queue_read(($urandom_range(5) == 0) ? $urandom_range(1) : SDA_RANDOM);
      endcase
      queue_idle_noise($urandom_range(2));
    end
  endtask

  // Wait until every item has gone in and every owed result has come out
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || results_owed.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [i2cm_pkg::CFG_DATA_W-1:0] data);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == i2cm_pkg::CFG_HALF_PERIOD)
      half_setting = data[i2cm_pkg::HALF_W-1:0];
    else
      limit_setting = data;
    @(negedge clk);
  endtask

  task automatic configure(input logic [i2cm_pkg::HALF_W-1:0] half,
                           input logic [i2cm_pkg::WAIT_W-1:0] limit, input int idle_pct);
    // Upper bits of the phase length write are don't-care for the engine
    write_reg(i2cm_pkg::CFG_HALF_PERIOD, {8'($urandom), half});
    write_reg(i2cm_pkg::CFG_ACK_LIMIT, limit);
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle items and undefined codes, then a start at reset settings
    // with a write command arriving while busy.
    queue_idle_noise(0);
    queue_item(i2cm_pkg::CMD_TICK, 8'h00, 1'b0);
    queue_item(CMD_SPARE_5, 8'hFF, 1'b1);
    queue_item(CMD_SPARE_6, 8'h00, 1'b0);
    queue_item(CMD_SPARE_7, 8'hFF, 1'b1);
    queue_item(i2cm_pkg::CMD_START, 8'h00, 1'b1);
    queue_item(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1);
    queue_ticks(2 * ticks_per_phase() - 1, SDA_RANDOM);

    // Zero phase length acts as one; a timeout followed by a write that must
    // clear both flags; reads of all ones and all zeros; a stop.
    configure(8'd0, 16'd2, 5);
    queue_write(8'hFF, 0, 1'b1);
    queue_write(8'h00, 2, 1'b0);
    queue_write(8'hA5, 1, 1'b1);
    queue_read(SDA_HIGH);
    queue_read(SDA_LOW);
    queue_condition(i2cm_pkg::CMD_STOP);

    // Random traffic at several settings
    configure(8'd1, 16'd0, 6);
    fill_sequences(180);

    configure(8'd2, 16'd1, 10);
    fill_sequences(70);
    @(negedge clk);
    hold_off_req = 1'b1;
    fill_sequences(70);
    // Let everything run dry before offering more
    drain();
    fill_sequences(50);

    configure(8'd3, 16'd5, 4);
    fill_sequences(110);

    // Longer phases and a longer ACK limit: one timed-out write, one read
    configure(8'd4, 16'd20, 3);
    queue_write(8'h96, 20, 1'b0);
    queue_read(SDA_RANDOM);

    // Unlimited wait held for a long stretch before the ACK
    configure(8'd1, 16'd0, 3);
    queue_write(8'h3C, 40, 1'b1);

    // Closing stretch without any idling on either side
    configure(8'd1, 16'd7, 0);
    fill_sequences(130);

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && results_owed.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
src/i2cm_pkg.sv
src/i2cm_core.sv
src/i2c_master_byte_engine.sv
verif/i2c_master_byte_engine_tb.sv
